/* hw/rtl/kst_pkg.sv */
// kst_pkg: shared types, sizes and codes for the keyed slot table
// no dependencies; used by kst_slot_mem, kst_ctrl and the top level

package kst_pkg;

    // table geometry
    localparam int SLOTS           = 128;
    localparam int MAX_ENTRY_BYTES = 1024;
    localparam int KEY_BITS        = 64;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // fixed field widths
    localparam int MODE_W   = 2;
    localparam int KEY_IN_W = 64;
    localparam int LEN_W    = 11;
    localparam int STAT_W   = 3;
    localparam int IDX_W    = 7;
    localparam int BYTES_W  = 16;

    localparam logic [BYTES_W-1:0] TOTAL_SPACE_RST = 16'd10240;
    localparam logic [LEN_W-1:0]   MAX_LEN         = LEN_W'(MAX_ENTRY_BYTES);

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_DELETE = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_EXISTS  = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_MISSING = 3'd3,
        STAT_NOSPACE = 3'd4
    } status_t;

    // one captured request
    typedef struct packed {
        mode_t                mode;
        logic [KEY_BITS-1:0]  key;
        logic [LEN_W-1:0]     len;
    } req_t;

    // one finished result
    typedef struct packed {
        status_t              status;
        logic [IDX_W-1:0]     idx;
        logic [LEN_W-1:0]     size;
        logic [BYTES_W-1:0]   used;
    } res_t;

    // slot memory write port
    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    addr;
        logic [KEY_BITS-1:0]  key;
        logic [LEN_W-1:0]     size;
    } mem_wr_t;

    // slot number to the reported index field
    function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
        logic [31:0] wide;
        begin
            wide = 32'(s);
            return wide[IDX_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/kst_slot_mem.sv */
// kst_slot_mem: key and size storage for every slot, one write and one read port
// depends on kst_pkg

module kst_slot_mem
(
    input  logic                          clk,
    input  kst_pkg::mem_wr_t              wr,
    input  logic                          rd_en,
    input  logic [kst_pkg::SLOT_W-1:0]    rd_addr,
    output logic [kst_pkg::KEY_BITS-1:0]  rd_key,
    output logic [kst_pkg::LEN_W-1:0]     rd_size
);

    logic [kst_pkg::KEY_BITS-1:0] key_mem_reg  [kst_pkg::SLOTS];
    logic [kst_pkg::LEN_W-1:0]    size_mem_reg [kst_pkg::SLOTS];
    logic [kst_pkg::KEY_BITS-1:0] rd_key_reg;
    logic [kst_pkg::LEN_W-1:0]    rd_size_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem_reg[wr.addr]  <= wr.key;
            size_mem_reg[wr.addr] <= wr.size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg  <= key_mem_reg[rd_addr];
            rd_size_reg <= size_mem_reg[rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_size = rd_size_reg;

endmodule

/* hw/rtl/kst_ctrl.sv */
// kst_ctrl: sequencer that walks all slots through one key compare unit,
// then applies the request; holds valid bits and the byte count
// depends on kst_pkg and kst_slot_mem

module kst_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  kst_pkg::req_t                 req,
    input  logic [kst_pkg::BYTES_W-1:0]   byte_budget,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_ready,
    output kst_pkg::res_t                 res
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [kst_pkg::SLOTS-1:0]       valid_reg, valid_next;
    logic [kst_pkg::BYTES_W-1:0]     used_reg, used_next;
    logic [kst_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [kst_pkg::SLOT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                            hit_found_reg, hit_found_next;
    logic [kst_pkg::SLOT_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [kst_pkg::LEN_W-1:0]       hit_size_reg, hit_size_next;
    logic                            free_found_reg, free_found_next;
    logic [kst_pkg::SLOT_W-1:0]      free_idx_reg, free_idx_next;
    kst_pkg::res_t                   res_reg, res_next;

    kst_pkg::mem_wr_t                mem_wr;
    logic                            rd_en;
    logic [kst_pkg::SLOT_W-1:0]      rd_addr;
    logic [kst_pkg::KEY_BITS-1:0]    rd_key;
    logic [kst_pkg::LEN_W-1:0]       rd_size;

    logic                            key_match;
    logic [kst_pkg::LEN_W-1:0]       len_sat;
    logic [kst_pkg::BYTES_W:0]       after_write;

    kst_slot_mem u_mem
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_size (rd_size)
    );

    // scan issues one slot address per cycle
    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg < kst_pkg::CNT_W'(kst_pkg::SLOTS));
    assign rd_addr = cnt_reg[kst_pkg::SLOT_W-1:0];

    // shared compare unit, one slot per cycle
    assign key_match = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_key == req.key);

    assign len_sat     = (req.len > kst_pkg::MAX_LEN) ? kst_pkg::MAX_LEN : req.len;
    assign after_write = {1'b0, used_reg} - {{(kst_pkg::BYTES_W + 1 - kst_pkg::LEN_W){1'b0}},
                         hit_size_reg} + {{(kst_pkg::BYTES_W + 1 - kst_pkg::LEN_W){1'b0}}, len_sat};

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        used_next       = used_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = rd_en;
        cmp_idx_next    = rd_addr;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_size_next   = hit_size_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_next        = res_reg;
        mem_wr.en       = 1'b0;
        mem_wr.addr     = hit_idx_reg;
        mem_wr.key      = req.key;
        mem_wr.size     = len_sat;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                // lowest matching slot and lowest free slot win
                if (key_match && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_size_next  = rd_size;
                end
                if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (cmp_vld_reg && (cmp_idx_reg == kst_pkg::SLOT_W'(kst_pkg::SLOTS - 1)))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next.status = kst_pkg::STAT_OK;
                res_next.idx    = '0;
                res_next.size   = '0;
                unique case (req.mode)
                    kst_pkg::MODE_CREATE:
                    begin
                        if (hit_found_reg)
                        begin
                            res_next.status = kst_pkg::STAT_EXISTS;
                        end
                        else if (!free_found_reg)
                        begin
                            res_next.status = kst_pkg::STAT_FULL;
                        end
                        else
                        begin
                            mem_wr.en                 = 1'b1;
                            mem_wr.addr               = free_idx_reg;
                            mem_wr.size               = '0;
                            valid_next[free_idx_reg]  = 1'b1;
                            res_next.idx              = kst_pkg::slot_to_idx(free_idx_reg);
                        end
                    end
                    kst_pkg::MODE_WRITE:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_next.status = kst_pkg::STAT_MISSING;
                        end
                        else if (after_write > {1'b0, byte_budget})
                        begin
                            res_next.status = kst_pkg::STAT_NOSPACE;
                        end
                        else
                        begin
                            mem_wr.en     = 1'b1;
                            used_next     = after_write[kst_pkg::BYTES_W-1:0];
                            res_next.idx  = kst_pkg::slot_to_idx(hit_idx_reg);
                            res_next.size = len_sat;
                        end
                    end
                    kst_pkg::MODE_READ:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_next.status = kst_pkg::STAT_MISSING;
                        end
                        else
                        begin
                            res_next.idx  = kst_pkg::slot_to_idx(hit_idx_reg);
                            res_next.size = hit_size_reg;
                        end
                    end
                    kst_pkg::MODE_DELETE:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_next.status = kst_pkg::STAT_MISSING;
                        end
                        else
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            used_next     = used_reg - kst_pkg::BYTES_W'(hit_size_reg);
                            res_next.idx  = kst_pkg::slot_to_idx(hit_idx_reg);
                            res_next.size = hit_size_reg;
                        end
                    end
                    default:
                    begin
                        res_next.status = kst_pkg::STAT_MISSING;
                    end
                endcase
                res_next.used = used_next;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            used_reg       <= '0;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            used_reg       <= used_next;
            cnt_reg        <= cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_size_reg  <= hit_size_next;
        free_idx_reg  <= free_idx_next;
        res_reg       <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // a captured hit still points at a live slot when the request is applied
    a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && hit_found_reg |-> valid_reg[hit_idx_reg])
        else $error("hit slot not valid at exec");

    // a captured free slot is still free when the request is applied
    a_free_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && free_found_reg |-> !valid_reg[free_idx_reg])
        else $error("free slot already valid at exec");

    // slot memory is only written while a request is applied
    a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> (state_reg == ST_EXEC))
        else $error("slot memory write outside exec");

    // compare pipeline never carries a slot outside the scan
    a_cmp_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (state_reg == ST_SCAN))
        else $error("compare stage active outside scan");

endmodule

/* hw/rtl/keyed_slot_table_with_quota_top.sv */
// keyed_slot_table_with_quota_top: stream wrapper, request capture, quota
// register and output register around the slot sequencer
// depends on kst_pkg and kst_ctrl (which holds kst_slot_mem)
//
//  channel  | signals                          | word
//  ---------+----------------------------------+---------------------------------------
//  request  | s_tvalid s_tready s_tdata s_tuser| tuser mode, tdata key + length
//  result   | m_tvalid m_tready m_tdata m_tuser| tuser status, tdata index, size, used
//  config   | cfg_valid cfg_ready cfg_data     | byte budget
//
// from accept to result, every slot is read once from the slot memory and
// checked by the single key compare unit, then ST_EXEC applies the request
// and ST_DONE presents it
// s_tready is high only while the sequencer is idle, so the next request is
// taken only after the last one has left the sequencer
// a stalled result holds in the output register; the sequencer finishes the
// next request and waits until that register frees
// reset clears all valid bits and the byte count at once, budget goes to 10240

module keyed_slot_table_with_quota_top
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // [63:0] name_key, [74:64] content_length, rest zero
    input  logic [1:0]   s_tuser,   // [1:0] mode

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // [6:0] slot_index, [17:7] entry_size, [33:18] used_bytes
    output logic [2:0]   m_tuser,   // [2:0] status

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // [15:0] byte budget
);

    kst_pkg::req_t                  req_reg;
    logic [kst_pkg::BYTES_W-1:0]    budget_reg;
    logic                           out_valid_reg, out_valid_next;
    kst_pkg::res_t                  out_reg;
    logic                           ctrl_idle;
    logic                           res_valid;
    logic                           out_free;
    logic                           in_take;
    kst_pkg::res_t                  res;

    assign s_tready  = ctrl_idle;
    assign cfg_ready = 1'b1;
    assign in_take   = s_tvalid && s_tready;

    // output register frees when empty or taken this cycle
    assign out_free = !out_valid_reg || m_tready;

    // request capture, key cut to the table's key width
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.mode <= kst_pkg::mode_t'(s_tuser);
            req_reg.key  <= s_tdata[kst_pkg::KEY_BITS-1:0];
            req_reg.len  <= s_tdata[kst_pkg::KEY_IN_W +: kst_pkg::LEN_W];
        end
    end

    // byte budget
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= kst_pkg::TOTAL_SPACE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            budget_reg <= cfg_data;
        end
    end

    kst_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_take),
        .req         (req_reg),
        .byte_budget (budget_reg),
        .idle        (ctrl_idle),
        .res_valid   (res_valid),
        .res_ready   (out_free),
        .res         (res)
    );

    // result word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'd0, out_reg.used, out_reg.size, out_reg.idx};

endmodule
